/* hdl/pat_pkg.sv */
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and constants for the prefix autocomplete table.
// ----------------------------------------------------------------------------
package pat_pkg;

   localparam int CHAR_BITS = 8;
   localparam logic [CHAR_BITS-1:0] STAR_CHAR = 8'h2A;   // '*'

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                 op;
      logic [CHAR_BITS-1:0] char_code;
      logic                 no_char;
      logic                 last;
   } req_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] out_char;
      logic                 out_last;
      logic                 empty_word;
      logic                 inserted;
      logic                 table_full;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START,
      ST_LOAD_COPY,
      ST_HDR,
      ST_HDR_CHK,
      ST_CMP_RD,
      ST_CMP_CHK,
      ST_MATCH,
      ST_TIE_RD,
      ST_TIE_CHK,
      ST_NEXT,
      ST_DECIDE,
      ST_EMIT_RD,
      ST_EMIT_TBL,
      ST_EMIT_BUF,
      ST_EMIT_EMPTY,
      ST_FINISH
   } state_type;

endpackage

/* hdl/prefix_autocomplete_table.sv */
// ----------------------------------------------------------------------------
// prefix_autocomplete_table
// Word table with use counts; completes query words by prefix or exact match and inserts unmatched ones.
// ----------------------------------------------------------------------------
// Sequence: a non-final character transaction is absorbed in idle; a final load
//   transaction copies the word into the table if there is room. A final query scans
//   every stored entry byte by byte with one byte comparator, with a byte-wise
//   tie-break on a count tie, then emits the result from the buffer or the table.
// Throughput: one word at a time, busy high through scan and emit; no stalls.
// Reset: synchronous; clears the sequencer, entry count, row base and word length only.
module prefix_autocomplete_table
   import pat_pkg::*;
#(
   parameter int TABLE_DEPTH  = 64,
   parameter int MAX_WORD_LEN = 20,
   parameter int COUNT_BITS   = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int AW = $clog2(TABLE_DEPTH * MAX_WORD_LEN);
   localparam int JW = $clog2(MAX_WORD_LEN + 1);
   localparam int XW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam logic [AW-1:0] ROW = AW'(MAX_WORD_LEN);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   // storage: characters, lengths, counts (no reset, read only once written)
   logic [CHAR_BITS-1:0]  chars_mem [TABLE_DEPTH*MAX_WORD_LEN];
   logic [JW-1:0]         len_mem   [TABLE_DEPTH];
   logic [COUNT_BITS-1:0] cnt_mem   [TABLE_DEPTH];
   logic [CHAR_BITS-1:0]  wbuf      [MAX_WORD_LEN];

   state_type state_ff, state_in;

   logic [IW:0]           used_ff;        // entries in use
   logic [AW-1:0]         used_base_ff;   // used_ff * MAX_WORD_LEN
   logic [JW-1:0]         wlen_ff;
   logic [CHAR_BITS-1:0]  lastch_ff;
   logic                  op_ff, exact_ff, found_ff, append_ff, ins_ff, full_ff;
   logic [IW:0]           idx_ff;         // entry under scan
   logic [AW-1:0]         base_ff;
   logic [JW-1:0]         j_ff;           // byte index
   logic [JW-1:0]         cur_len_ff, best_len_ff;
   logic [COUNT_BITS-1:0] cur_cnt_ff, best_cnt_ff;
   logic [IW-1:0]         best_idx_ff;
   logic [AW-1:0]         best_base_ff;

   // registered read data
   logic [CHAR_BITS-1:0]  rd_a_ff, rd_b_ff;
   logic [JW-1:0]         len_rd_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;

   logic [AW-1:0]         addr_a, addr_b, addr_w;
   logic                  chars_we, meta_we;
   logic [IW-1:0]         meta_addr;
   logic [JW-1:0]         meta_len;
   logic [COUNT_BITS-1:0] meta_cnt;

   logic [CHAR_BITS-1:0]  wch;
   logic [JW-1:0]         j_inc, min_len;
   logic                  room, len_ok, take, tie;
   logic                  accept;

   assign accept  = start && !busy;
   assign room    = (used_ff < (IW+1)'(TABLE_DEPTH));
   assign wch     = wbuf[j_ff[XW-1:0]];
   assign j_inc   = j_ff + JW'(1);
   assign min_len = (cur_len_ff < best_len_ff) ? cur_len_ff : best_len_ff;
   assign len_ok  = exact_ff ? (len_rd_ff == wlen_ff) : (len_rd_ff >= wlen_ff);
   // exact mode: last equal entry wins; prefix mode: higher count wins
   assign take    = exact_ff || !found_ff || (cur_cnt_ff > best_cnt_ff);
   assign tie     = !take && (cur_cnt_ff == best_cnt_ff);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.last) state_in = ST_START;
         end
         ST_START: begin
            if (op_ff == OP_LOAD)
               state_in = (room && wlen_ff != '0) ? ST_LOAD_COPY : ST_FINISH;
            else
               state_in = (used_ff == '0) ? ST_DECIDE : ST_HDR;
         end
         ST_LOAD_COPY: begin
            if (j_inc == wlen_ff) state_in = ST_FINISH;
         end
         ST_HDR: state_in = ST_HDR_CHK;
         ST_HDR_CHK: begin
            if (!len_ok)               state_in = ST_NEXT;
            else if (wlen_ff == '0)    state_in = ST_MATCH;
            else                       state_in = ST_CMP_RD;
         end
         ST_CMP_RD: state_in = ST_CMP_CHK;
         ST_CMP_CHK: begin
            if (rd_a_ff != wch)        state_in = ST_NEXT;
            else if (j_inc == wlen_ff) state_in = ST_MATCH;
            else                       state_in = ST_CMP_RD;
         end
         ST_MATCH: begin
            state_in = (tie && min_len != '0) ? ST_TIE_RD : ST_NEXT;
         end
         ST_TIE_RD: state_in = ST_TIE_CHK;
         ST_TIE_CHK: begin
            if (rd_a_ff != rd_b_ff || j_inc == min_len) state_in = ST_NEXT;
            else                                         state_in = ST_TIE_RD;
         end
         ST_NEXT: begin
            state_in = (idx_ff + (IW+1)'(1) == used_ff) ? ST_DECIDE : ST_HDR;
         end
         ST_DECIDE: begin
            if (found_ff)
               state_in = (best_len_ff == '0) ? ST_EMIT_EMPTY : ST_EMIT_RD;
            else
               state_in = (wlen_ff == '0) ? ST_EMIT_EMPTY : ST_EMIT_BUF;
         end
         ST_EMIT_RD: state_in = ST_EMIT_TBL;
         ST_EMIT_TBL: begin
            if (j_inc == best_len_ff) state_in = ST_FINISH;
            else                      state_in = ST_EMIT_RD;
         end
         ST_EMIT_BUF: begin
            if (j_inc == wlen_ff) state_in = ST_FINISH;
         end
         ST_EMIT_EMPTY: state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- outputs and memory controls ----------------
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = 1'b0;
      rsp_data  = '0;
      addr_a    = base_ff + AW'(j_ff);
      addr_b    = best_base_ff + AW'(j_ff);
      addr_w    = used_base_ff + AW'(j_ff);
      chars_we  = 1'b0;
      meta_we   = 1'b0;
      meta_addr = used_ff[IW-1:0];
      meta_len  = wlen_ff;
      meta_cnt  = '0;
      unique case (state_ff)
         ST_START: begin
            meta_we = (op_ff == OP_LOAD) && room;
         end
         ST_LOAD_COPY: chars_we = 1'b1;
         ST_DECIDE: begin
            if (found_ff) begin
               meta_we   = 1'b1;
               meta_addr = best_idx_ff;
               meta_len  = best_len_ff;
               meta_cnt  = (best_cnt_ff != CNT_MAX) ? best_cnt_ff + COUNT_BITS'(1)
                                                    : best_cnt_ff;
            end else begin
               meta_we  = room;
               meta_cnt = COUNT_BITS'(1);
            end
         end
         ST_EMIT_RD: addr_a = best_base_ff + AW'(j_ff);
         ST_EMIT_TBL: begin
            rsp_valid           = 1'b1;
            rsp_data.out_char   = rd_a_ff;
            rsp_data.out_last   = (j_inc == best_len_ff);
         end
         ST_EMIT_BUF: begin
            rsp_valid           = 1'b1;
            chars_we            = append_ff;
            rsp_data.out_char   = wch;
            rsp_data.out_last   = (j_inc == wlen_ff);
            rsp_data.inserted   = ins_ff;
            rsp_data.table_full = full_ff;
         end
         ST_EMIT_EMPTY: begin
            rsp_valid           = 1'b1;
            rsp_data.out_last   = 1'b1;
            rsp_data.empty_word = 1'b1;
            rsp_data.inserted   = ins_ff;
            rsp_data.table_full = full_ff;
         end
         default: begin
         end
      endcase
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (chars_we) chars_mem[addr_w] <= wch;
      rd_a_ff <= chars_mem[addr_a];
      rd_b_ff <= chars_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         len_mem[meta_addr] <= meta_len;
         cnt_mem[meta_addr] <= meta_cnt;
      end
      len_rd_ff <= len_mem[idx_ff[IW-1:0]];
      cnt_rd_ff <= cnt_mem[idx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept && !req_data.no_char && wlen_ff < JW'(MAX_WORD_LEN))
         wbuf[wlen_ff[XW-1:0]] <= req_data.char_code;
   end

   // ---------------- sequencer datapath ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         used_base_ff <= '0;
         wlen_ff      <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (!req_data.no_char && wlen_ff < JW'(MAX_WORD_LEN)) begin
                     wlen_ff   <= wlen_ff + JW'(1);
                     lastch_ff <= req_data.char_code;
                  end
                  op_ff <= req_data.op;
               end
            end
            ST_START: begin
               j_ff      <= '0;
               idx_ff    <= '0;
               base_ff   <= '0;
               found_ff  <= 1'b0;
               ins_ff    <= 1'b0;
               full_ff   <= 1'b0;
               exact_ff  <= 1'b0;
               append_ff <= (op_ff == OP_LOAD) && room;
               // trailing star asks for an exact match and is dropped
               if (op_ff == OP_QUERY && wlen_ff != '0 && lastch_ff == STAR_CHAR) begin
                  exact_ff <= 1'b1;
                  wlen_ff  <= wlen_ff - JW'(1);
               end
            end
            ST_LOAD_COPY: j_ff <= j_inc;
            ST_HDR_CHK: begin
               cur_len_ff <= len_rd_ff;
               cur_cnt_ff <= cnt_rd_ff;
               j_ff       <= '0;
            end
            ST_CMP_CHK: j_ff <= j_inc;
            ST_MATCH: begin
               j_ff <= '0;
               if (take || (tie && min_len == '0 && cur_len_ff < best_len_ff)) begin
                  found_ff     <= 1'b1;
                  best_idx_ff  <= idx_ff[IW-1:0];
                  best_base_ff <= base_ff;
                  best_len_ff  <= cur_len_ff;
                  best_cnt_ff  <= cur_cnt_ff;
               end
            end
            ST_TIE_CHK: begin
               j_ff <= j_inc;
               // byte-wise smaller word wins; a proper prefix ranks lower
               if ((rd_a_ff < rd_b_ff) ||
                   (rd_a_ff == rd_b_ff && j_inc == min_len && cur_len_ff < best_len_ff))
               begin
                  best_idx_ff  <= idx_ff[IW-1:0];
                  best_base_ff <= base_ff;
                  best_len_ff  <= cur_len_ff;
                  best_cnt_ff  <= cur_cnt_ff;
               end
            end
            ST_NEXT: begin
               idx_ff  <= idx_ff + (IW+1)'(1);
               base_ff <= base_ff + ROW;
            end
            ST_DECIDE: begin
               j_ff <= '0;
               if (found_ff) begin
                  best_cnt_ff <= meta_cnt;
               end else if (room) begin
                  ins_ff    <= 1'b1;
                  append_ff <= 1'b1;
               end else begin
                  full_ff <= 1'b1;
               end
            end
            ST_EMIT_TBL: j_ff <= j_inc;
            ST_EMIT_BUF: j_ff <= j_inc;
            ST_FINISH: begin
               wlen_ff <= '0;
               if (append_ff) begin
                  used_ff      <= used_ff + (IW+1)'(1);
                  used_base_ff <= used_base_ff + ROW;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

/* hdl/pat_checker.sv */
// ----------------------------------------------------------------------------
// pat_checker
// Port-level assertions for the prefix autocomplete table.
// ----------------------------------------------------------------------------
module pat_checker
   import pat_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // results only come out while a word is in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside a busy window");

   // the final character of a word closes the transaction burst
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_last |=> !rsp_valid)
      else $error("result after final character");

   // empty result is a single zero character
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_word |-> rsp_data.out_last && rsp_data.out_char == '0)
      else $error("bad empty result");

   // a non-final character is absorbed without going busy
   a_mid_char: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_data.last |=> !busy)
      else $error("busy after a non-final character");

   // reset leaves the block idle
   a_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !busy && !rsp_valid)
      else $error("busy after reset");

endmodule

bind prefix_autocomplete_table pat_checker u_pat_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
